### sv/pcke_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcke_pkg
// Shared types and constants for the set-1 scan-code emitter.
// ----------------------------------------------------------------------------
package pcke_pkg;

    localparam int KEY_COUNT = 128;
    localparam int KEY_W     = $clog2(KEY_COUNT);

    // request modes
    localparam logic [1:0] MODE_EVENT = 2'd0;
    localparam logic [1:0] MODE_PEEK  = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // config register indexes
    localparam logic CFG_SERVICE = 1'b0;
    localparam logic CFG_PAUSE   = 1'b1;

    localparam logic [6:0] PAUSE_CODE_RST = 7'd69;
    localparam logic [7:0] EXT_PREFIX     = 8'he0;
    localparam logic [7:0] BREAK_BIT      = 8'h80;
    localparam logic [2:0] PAUSE_LEN      = 3'd6;

    typedef struct packed {
        logic [1:0]  mode;
        logic [6:0]  key_code;
        logic        key_pressed;
        logic        key_repeated;
        logic        key_extended;
        logic [31:0] current_time;
    } item_t;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  scan_byte;
        logic        last_of_run;
        logic [6:0]  read_code;
        logic [6:0]  repeat_key;
        logic        repeat_key_extended;
        logic [31:0] repeat_press_time;
    } result_t;

    typedef enum logic [1:0] {
        RUN_NONE,
        RUN_PAUSE,
        RUN_CODE
    } run_kind_t;

    // everything needed to replay the beats of one item
    typedef struct packed {
        run_kind_t   kind;
        logic        ext;
        logic [7:0]  code_byte;
        logic [6:0]  read_code;
        logic [6:0]  repeat_key;
        logic        repeat_ext;
        logic [31:0] repeat_time;
    } run_t;

    function automatic logic [7:0] pause_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'he1;
            3'd1:    b = 8'h1d;
            3'd2:    b = 8'h45;
            3'd3:    b = 8'he1;
            3'd4:    b = 8'h9d;
            3'd5:    b = 8'hc5;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

### sv/pcke_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcke_eval
// Key state, code latch and repeat tracking; decides the beats of one item.
// ----------------------------------------------------------------------------
module pcke_eval
    import pcke_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       service_en,
    input  wire logic [6:0] pause_code,
    input  wire item_t      item,
    input  wire logic       commit,
    output run_t            run
);

    logic [KEY_COUNT-1:0] key_down_reg, key_down_next;
    logic [6:0]           latch_reg, latch_next;
    logic [6:0]           last_key_reg, last_key_next;
    logic                 last_ext_reg, last_ext_next;
    logic [31:0]          last_time_reg, last_time_next;

    logic [KEY_W-1:0] key_idx;
    logic             is_pause;
    logic             take;
    run_kind_t        kind;
    logic [6:0]       rd;

    assign key_idx  = KEY_W'(item.key_code);
    assign is_pause = (item.key_code == pause_code);
    // drop an event that restates the stored key state, unless repeated
    assign take     = (item.key_pressed != key_down_reg[key_idx]) || item.key_repeated;

    always_comb
    begin
        key_down_next  = key_down_reg;
        latch_next     = latch_reg;
        last_key_next  = last_key_reg;
        last_ext_next  = last_ext_reg;
        last_time_next = last_time_reg;
        kind           = RUN_NONE;
        rd             = 7'd0;
        unique case (item.mode)
            MODE_PEEK:
            begin
                rd = latch_reg;
            end
            MODE_READ:
            begin
                rd         = latch_reg;
                latch_next = 7'd0;
            end
            MODE_EVENT:
            begin
                if (is_pause)
                begin
                    if (item.key_pressed && service_en)
                    begin
                        kind          = RUN_PAUSE;
                        last_key_next = 7'd0;
                    end
                end
                else if (take)
                begin
                    if (service_en)
                        kind = RUN_CODE;
                    else if (item.key_pressed)
                        latch_next = item.key_code;
                    key_down_next[key_idx] = item.key_pressed;
                    if (!item.key_pressed)
                        last_key_next = 7'd0;
                    else if (!item.key_repeated)
                    begin
                        last_key_next  = item.key_code;
                        last_ext_next  = item.key_extended;
                        last_time_next = item.current_time;
                    end
                end
            end
            default:
            begin
                // unused mode: no state change
            end
        endcase
    end

    always_comb
    begin
        run.kind        = kind;
        run.ext         = item.key_extended;
        run.code_byte   = {1'b0, item.key_code} | (item.key_pressed ? 8'h00 : BREAK_BIT);
        run.read_code   = rd;
        run.repeat_key  = last_key_next;
        run.repeat_ext  = last_ext_next;
        run.repeat_time = last_time_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_down_reg  <= '0;
            latch_reg     <= 7'd0;
            last_key_reg  <= 7'd0;
            last_ext_reg  <= 1'b0;
            last_time_reg <= 32'd0;
        end
        else if (commit)
        begin
            key_down_reg  <= key_down_next;
            latch_reg     <= latch_next;
            last_key_reg  <= last_key_next;
            last_ext_reg  <= last_ext_next;
            last_time_reg <= last_time_next;
        end
    end

endmodule
`default_nettype wire

### sv/pc_keyboard_scancode_emitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pc_keyboard_scancode_emitter
// Emulated keyboard: key events in, set-1 scan-code beats out.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) carries key events (mode 0)
//   and latch reads (mode 1 peek, mode 2 read and clear).
//   result channel (result_valid/result_ready/result) returns one beat per
//   scan byte sent, or a single beat with byte_valid low when nothing is
//   sent; last_of_run marks the final beat of each item.
//   cfg_we/cfg_index/cfg_data write service_enabled (0) or pause_code (1);
//   write only while the block is idle.
// Pipeline: an accepted item goes to the input register, then to the run
//   register, which loads it when the output is free; its beats go out from there.
// Throughput: one beat per cycle while result_ready is high; an item has as
//   many beats as listed (1, 2 for an extended key, 6 for pause), and the
//   next item is evaluated in the cycle its predecessor's last beat leaves,
//   so single-beat items flow at one per cycle.
// Reset: all key-down bits, the latch and repeat tracking clear; the
//   service is off and pause_code is 69.
// Stall: with result_ready low the current beat holds; one item waits in
//   the input register, then item_ready drops.
// ----------------------------------------------------------------------------
module pc_keyboard_scancode_emitter
    import pcke_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [6:0] cfg_data,
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire item_t      item,
    output logic            result_valid,
    input  wire logic       result_ready,
    output result_t         result
);

    // configuration
    logic       service_en_reg;
    logic [6:0] pause_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            service_en_reg <= 1'b0;
            pause_code_reg <= PAUSE_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SERVICE: service_en_reg <= cfg_data[0];
                CFG_PAUSE:   pause_code_reg <= cfg_data;
            endcase
        end
    end

    // input register
    item_t item_reg;
    logic  item_valid_reg;

    // run register: the decoded beats of the item being sent
    run_t       run_reg;
    logic       run_valid_reg;
    logic [2:0] beat_reg;

    run_t       run_next;
    logic       run_load;
    logic       beat_fire;
    logic       beat_last;
    logic [2:0] beat_count;

    always_comb
    begin
        unique case (run_reg.kind)
            RUN_PAUSE: beat_count = PAUSE_LEN;
            RUN_CODE:  beat_count = run_reg.ext ? 3'd2 : 3'd1;
            default:   beat_count = 3'd1;
        endcase
    end

    assign beat_last  = (beat_reg == beat_count - 3'd1);
    assign beat_fire  = run_valid_reg && result_ready;
    // evaluate the waiting item once the output has room for its run
    assign run_load   = item_valid_reg && (!run_valid_reg || (beat_fire && beat_last));
    assign item_ready = !item_valid_reg || run_load;

    pcke_eval u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .service_en (service_en_reg),
        .pause_code (pause_code_reg),
        .item       (item_reg),
        .commit     (run_load),
        .run        (run_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (item_ready)
            item_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_valid_reg <= 1'b0;
            beat_reg      <= 3'd0;
        end
        else if (run_load)
        begin
            run_valid_reg <= 1'b1;
            beat_reg      <= 3'd0;
        end
        else if (beat_fire)
        begin
            if (beat_last)
                run_valid_reg <= 1'b0;
            else
                beat_reg <= beat_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_load)
            run_reg <= run_next;
    end

    // beat formatting
    always_comb
    begin
        result.byte_valid = 1'b0;
        result.scan_byte  = 8'h00;
        unique case (run_reg.kind)
            RUN_PAUSE:
            begin
                result.byte_valid = 1'b1;
                result.scan_byte  = pause_byte(beat_reg);
            end
            RUN_CODE:
            begin
                result.byte_valid = 1'b1;
                result.scan_byte  = (run_reg.ext && beat_reg == 3'd0) ? EXT_PREFIX
                                                                      : run_reg.code_byte;
            end
            default:
            begin
                result.byte_valid = 1'b0;
                result.scan_byte  = 8'h00;
            end
        endcase
        result.last_of_run         = beat_last;
        result.read_code           = run_reg.read_code;
        result.repeat_key          = run_reg.repeat_key;
        result.repeat_key_extended = run_reg.repeat_ext;
        result.repeat_press_time   = run_reg.repeat_time;
    end

    assign result_valid = run_valid_reg;

endmodule
`default_nettype wire
